>>> hw/rtl/trms_pkg.sv
// Package for the toy register machine step block.
// Holds sizes, operand/opcode/error codes, the beat payload types and range checks.
// No dependencies; every other file in hw/rtl except trms_ram imports it.
package trms_pkg;

	localparam int MEM_WORDS  = 64;
	localparam int REG_COUNT  = 5;
	localparam int PC_BITS    = 16;
	localparam int DATA_W     = 32;
	localparam int PC_OUT_W   = 16;
	localparam int REG_IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int MEM_IDX_W  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam logic [63:0] PC_MASK = (64'd1 << PC_BITS) - 64'd1;

	typedef enum logic [2:0] {
		OP_MOV, OP_ADD, OP_SUB, OP_JMP, OP_JPN, OP_PRN, OP_HLT, OP_BAD
	} op_t;

	typedef enum logic [1:0] {
		KIND_REG, KIND_MEM, KIND_CONST, KIND_NONE
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_FORM = 3'd1,
		ERR_ADDR = 3'd2,
		ERR_REG  = 3'd3,
		ERR_OP   = 3'd4
	} err_t;

	typedef struct packed {
		op_t                      op;
		kind_t                    first_kind;
		logic signed [DATA_W-1:0] first_value;
		kind_t                    second_kind;
		logic signed [DATA_W-1:0] second_value;
	} instr_t;

	typedef struct packed {
		logic [PC_OUT_W-1:0]      pc_after;
		logic                     print_valid;
		logic signed [DATA_W-1:0] print_value;
		logic                     halted;
		err_t                     error_code;
	} result_t;

	function automatic logic reg_ok(logic signed [DATA_W-1:0] v);
		return (v >= 32'sd1) && (v <= 32'(REG_COUNT));
	endfunction

	function automatic logic mem_ok(logic signed [DATA_W-1:0] v);
		return !v[DATA_W-1] && (v < 32'(MEM_WORDS));
	endfunction

	function automatic logic target_ok(logic signed [DATA_W-1:0] v);
		return !v[DATA_W-1] && ({32'd0, v} <= PC_MASK);
	endfunction

endpackage

>>> hw/rtl/trms_if.sv
// Valid/ready channels for instruction beats and result beats.
// Depends on trms_pkg for the payload types.
interface instr_if import trms_pkg::*; ();
	logic   valid;
	logic   ready;
	instr_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface result_if import trms_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/trms_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No package dependency.
module trms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/toy_register_machine_step.sv
// Pipeline: read stage, execute stage, output register. Throughput: one instruction per
// cycle unless result beats are held back; register file and data memory are read when the
// beat is taken and written back from the execute stage, with bypass for back-to-back use.
// Reset: asynchronous; line counter to 1, halt cleared, all register and memory entries
// read as zero via per-entry valid bits, so there is no clearing pass.
module toy_register_machine_step import trms_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	instr_if.sink       instr,
	result_if.source    result
);

	logic acc, adv, fire;

	// read stage
	logic                 vld_s1;
	instr_t               ins_s1;
	logic                 byp_a_s1, byp_b_s1, byp_m_s1;
	logic [DATA_W-1:0]    byp_a_d_s1, byp_b_d_s1, byp_m_d_s1;
	logic                 ev_a_s1, ev_b_s1, ev_m_s1;

	logic [REG_IDX_W-1:0] ra_idx, rb_idx;
	logic [MEM_IDX_W-1:0] m_idx;
	logic signed [DATA_W-1:0] m_sel;
	logic                 ev_a, ev_b, ev_m;

	// architectural state
	logic [REG_COUNT-1:0] reg_vld_q;
	logic [MEM_WORDS-1:0] mem_vld_q;
	logic [PC_BITS-1:0]   pc_q;
	logic                 halt_q;

	// RAM ports
	logic [DATA_W-1:0]    ram_a_rd, ram_b_rd, ram_m_rd;
	logic                 reg_we, mem_we;
	logic [REG_IDX_W-1:0] reg_widx;
	logic [MEM_IDX_W-1:0] mem_widx;
	logic [DATA_W-1:0]    reg_wd, mem_wd;

	// execute
	logic [DATA_W-1:0]    ra, rb, mv, opnd;
	logic [REG_IDX_W-1:0] xa_idx, xb_idx;
	logic [MEM_IDX_W-1:0] xm1_idx, xm2_idx;
	err_t                 err;
	logic                 jump, hlt, printed, rwe, mwe, commit;
	logic [DATA_W-1:0]    tgt, pval;
	logic [PC_BITS-1:0]   pc_next;
	result_t              res;

	// output register
	logic                 out_vld_q;
	result_t              out_q;

	assign adv         = !out_vld_q || result.ready;
	assign fire        = vld_s1 && adv;
	assign instr.ready = !vld_s1 || adv;
	assign acc         = instr.valid && instr.ready;

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	// ---------------------------------------------------------------- read stage
	always_comb begin
		ra_idx = REG_IDX_W'(instr.data.first_value - 32'sd1);
		rb_idx = REG_IDX_W'(instr.data.second_value - 32'sd1);
		m_sel  = (instr.data.op == OP_ADD || instr.data.op == OP_SUB) ?
			instr.data.second_value : instr.data.first_value;
		m_idx  = m_sel[MEM_IDX_W-1:0];
		ev_a   = ({1'b0, ra_idx} < (REG_IDX_W+1)'(REG_COUNT)) ? reg_vld_q[ra_idx] : 1'b0;
		ev_b   = ({1'b0, rb_idx} < (REG_IDX_W+1)'(REG_COUNT)) ? reg_vld_q[rb_idx] : 1'b0;
		ev_m   = ({1'b0, m_idx} < (MEM_IDX_W+1)'(MEM_WORDS)) ? mem_vld_q[m_idx] : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// catch a write-back landing on the same entry as this beat's read
	always_ff @(posedge clk) begin
		if (acc) begin
			ins_s1     <= instr.data;
			byp_a_s1   <= reg_we && (reg_widx == ra_idx);
			byp_b_s1   <= reg_we && (reg_widx == rb_idx);
			byp_m_s1   <= mem_we && (mem_widx == m_idx);
			byp_a_d_s1 <= reg_wd;
			byp_b_d_s1 <= reg_wd;
			byp_m_d_s1 <= mem_wd;
			ev_a_s1    <= ev_a;
			ev_b_s1    <= ev_b;
			ev_m_s1    <= ev_m;
		end
	end

	trms_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_regs_a (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_widx),
		.wdata (reg_wd),
		.re    (acc),
		.raddr (ra_idx),
		.rdata (ram_a_rd)
	);

	trms_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_regs_b (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_widx),
		.wdata (reg_wd),
		.re    (acc),
		.raddr (rb_idx),
		.rdata (ram_b_rd)
	);

	trms_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_widx),
		.wdata (mem_wd),
		.re    (acc),
		.raddr (m_idx),
		.rdata (ram_m_rd)
	);

	// ------------------------------------------------------------- execute stage
	always_comb begin
		ra = byp_a_s1 ? byp_a_d_s1 : (ev_a_s1 ? ram_a_rd : '0);
		rb = byp_b_s1 ? byp_b_d_s1 : (ev_b_s1 ? ram_b_rd : '0);
		mv = byp_m_s1 ? byp_m_d_s1 : (ev_m_s1 ? ram_m_rd : '0);
		xa_idx  = REG_IDX_W'(ins_s1.first_value - 32'sd1);
		xb_idx  = REG_IDX_W'(ins_s1.second_value - 32'sd1);
		xm1_idx = ins_s1.first_value[MEM_IDX_W-1:0];
		xm2_idx = ins_s1.second_value[MEM_IDX_W-1:0];
	end

	always_comb begin
		err      = ERR_NONE;
		jump     = 1'b0;
		hlt      = 1'b0;
		printed  = 1'b0;
		pval     = '0;
		tgt      = ins_s1.first_value;
		opnd     = '0;
		rwe      = 1'b0;
		reg_widx = xa_idx;
		reg_wd   = ra;
		mwe      = 1'b0;
		mem_widx = xm1_idx;
		mem_wd   = ra;
		unique case (ins_s1.op)
			OP_MOV: begin
				unique case (ins_s1.first_kind)
					KIND_REG: begin
						if (!reg_ok(ins_s1.first_value)) begin
							err = ERR_REG;
						end else begin
							unique case (ins_s1.second_kind)
								KIND_REG: begin
									if (!reg_ok(ins_s1.second_value)) begin
										err = ERR_REG;
									end else begin
										rwe      = 1'b1;
										reg_widx = xb_idx;
									end
								end
								KIND_MEM: begin
									if (!mem_ok(ins_s1.second_value)) begin
										err = ERR_ADDR;
									end else begin
										mwe      = 1'b1;
										mem_widx = xm2_idx;
									end
								end
								KIND_CONST: begin
									rwe    = 1'b1;
									reg_wd = ins_s1.second_value;
								end
								KIND_NONE: err = ERR_FORM;
							endcase
						end
					end
					KIND_MEM: begin
						if (!mem_ok(ins_s1.first_value)) begin
							err = ERR_ADDR;
						end else if (ins_s1.second_kind == KIND_REG) begin
							if (!reg_ok(ins_s1.second_value)) begin
								err = ERR_REG;
							end else begin
								rwe      = 1'b1;
								reg_widx = xb_idx;
								reg_wd   = mv;
							end
						end else if (ins_s1.second_kind == KIND_CONST) begin
							mwe    = 1'b1;
							mem_wd = ins_s1.second_value;
						end else begin
							err = ERR_FORM;
						end
					end
					KIND_CONST, KIND_NONE: err = ERR_FORM;
				endcase
			end
			OP_ADD, OP_SUB: begin
				if (ins_s1.first_kind != KIND_REG) begin
					err = ERR_FORM;
				end else if (!reg_ok(ins_s1.first_value)) begin
					err = ERR_REG;
				end else begin
					unique case (ins_s1.second_kind)
						KIND_REG: begin
							if (!reg_ok(ins_s1.second_value)) err = ERR_REG;
							opnd = rb;
						end
						KIND_MEM: begin
							if (!mem_ok(ins_s1.second_value)) err = ERR_ADDR;
							opnd = mv;
						end
						KIND_CONST: opnd = ins_s1.second_value;
						KIND_NONE:  err = ERR_FORM;
					endcase
					rwe    = (err == ERR_NONE);
					reg_wd = (ins_s1.op == OP_SUB) ? ra - opnd : ra + opnd;
				end
			end
			OP_JMP, OP_JPN: begin
				if (ins_s1.op == OP_JMP && ins_s1.first_kind == KIND_CONST) begin
					if (!target_ok(ins_s1.first_value)) err = ERR_ADDR;
					else jump = 1'b1;
				end else if (ins_s1.first_kind != KIND_REG) begin
					err = ERR_FORM;
				end else if (!reg_ok(ins_s1.first_value)) begin
					err = ERR_REG;
				end else if (ins_s1.second_kind != KIND_CONST) begin
					err = ERR_FORM;
				end else if (!target_ok(ins_s1.second_value)) begin
					err = ERR_ADDR;
				end else begin
					tgt  = ins_s1.second_value;
					jump = (ra == '0) || (ins_s1.op == OP_JPN && ra[DATA_W-1]);
				end
			end
			OP_PRN: begin
				unique case (ins_s1.first_kind)
					KIND_REG: begin
						if (!reg_ok(ins_s1.first_value)) err = ERR_REG;
						else pval = ra;
					end
					KIND_MEM: begin
						if (!mem_ok(ins_s1.first_value)) err = ERR_ADDR;
						else pval = mv;
					end
					KIND_CONST: pval = ins_s1.first_value;
					KIND_NONE:  err = ERR_FORM;
				endcase
				printed = (err == ERR_NONE);
			end
			OP_HLT: hlt = 1'b1;
			OP_BAD: err = ERR_OP;
		endcase

		// drop register and memory writes on error or once halted; an error also drops the jump
		commit  = fire && !halt_q && (err == ERR_NONE);
		reg_we  = commit && rwe;
		mem_we  = commit && mwe;
		pc_next = (jump && err == ERR_NONE) ? tgt[PC_BITS-1:0] : pc_q + PC_BITS'(1);

		if (halt_q) begin
			res.pc_after    = PC_OUT_W'(pc_q);
			res.print_valid = 1'b0;
			res.print_value = '0;
			res.halted      = 1'b1;
			res.error_code  = ERR_NONE;
		end else begin
			res.pc_after    = PC_OUT_W'(pc_next);
			res.print_valid = printed;
			res.print_value = printed ? pval : '0;
			res.halted      = hlt || (err != ERR_NONE);
			res.error_code  = err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_BITS'(1);
			halt_q    <= 1'b0;
			reg_vld_q <= '0;
			mem_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire && !halt_q) begin
				pc_q   <= pc_next;
				halt_q <= hlt || (err != ERR_NONE);
			end
			if (reg_we) begin
				reg_vld_q[reg_widx] <= 1'b1;
			end
			if (mem_we) begin
				mem_vld_q[mem_widx] <= 1'b1;
			end
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

endmodule

>>> hw/rtl/trms_checker.sv
// Port-level checks on the result beats of toy_register_machine_step, bound to the top.
// Depends on trms_pkg for the result payload type and error codes.
module trms_checker import trms_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input result_t res
);

	logic                beat;
	logic                seen_halt_q;
	logic [PC_OUT_W-1:0] halt_pc_q;

	assign beat = out_valid && out_ready;

	// remember the line counter reported by the first halted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
			halt_pc_q   <= '0;
		end else if (beat && res.halted && !seen_halt_q) begin
			seen_halt_q <= 1'b1;
			halt_pc_q   <= res.pc_after;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res))
		else $error("result beat changed while stalled");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		beat && res.error_code != ERR_NONE |-> res.halted && !res.print_valid)
		else $error("error beat without halt or with print");

	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !res.print_valid |-> res.print_value == '0)
		else $error("print value set without print");

	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		beat && seen_halt_q |->
			res.halted && res.pc_after == halt_pc_q && res.error_code == ERR_NONE &&
			!res.print_valid)
		else $error("machine state moved after halt");

endmodule

bind toy_register_machine_step trms_checker u_trms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.res       (result.data)
);

>>> tb/sv/trms_result_check.sv
`timescale 1ns / 1ps
// Result checker for the toy register machine step block: follows every instruction
// beat, predicts its result beat and compares it with what the block returns.
// Depends on trms_pkg and on the instr_if / result_if channels.
module trms_result_check import trms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	instr_if     instr,
	result_if    result,
	output int   mismatches,
	output int   in_flight
);

	logic [DATA_W-1:0]  reg_file [1:REG_COUNT];
	logic [DATA_W-1:0]  data_mem [MEM_WORDS];
	logic [PC_BITS-1:0] line_pc;
	logic               machine_halted;
	result_t            expected_q [$];
	int                 fault_count;

	function automatic bit reg_num_in_range(longint n);
		return n >= 1 && n <= REG_COUNT;
	endfunction

	function automatic bit addr_in_range(longint a);
		return a >= 0 && a < MEM_WORDS;
	endfunction

	function automatic bit target_in_range(longint t);
		return t >= 0 && t < (longint'(1) << PC_BITS);
	endfunction

	function automatic err_t fetch_operand(kind_t k, longint v, output logic [DATA_W-1:0] val);
		val = '0;
		case (k)
		KIND_REG: begin
			if (!reg_num_in_range(v))
				return ERR_REG;
			val = reg_file[v];
		end
		KIND_MEM: begin
			if (!addr_in_range(v))
				return ERR_ADDR;
			val = data_mem[v];
		end
		KIND_CONST: val = v[DATA_W-1:0];
		default: return ERR_FORM;
		endcase
		return ERR_NONE;
	endfunction

	function automatic err_t exec_mov(instr_t ins);
		longint            v1;
		longint            v2;
		logic [DATA_W-1:0] c2;
		v1 = longint'($signed(ins.first_value));
		v2 = longint'($signed(ins.second_value));
		c2 = ins.second_value;
		case (ins.first_kind)
		KIND_REG: begin
			if (!reg_num_in_range(v1))
				return ERR_REG;
			case (ins.second_kind)
			KIND_REG: begin
				if (!reg_num_in_range(v2))
					return ERR_REG;
				reg_file[v2] = reg_file[v1];
			end
			KIND_MEM: begin
				if (!addr_in_range(v2))
					return ERR_ADDR;
				data_mem[v2] = reg_file[v1];
			end
			KIND_CONST: reg_file[v1] = c2;
			default: return ERR_FORM;
			endcase
		end
		KIND_MEM: begin
			if (!addr_in_range(v1))
				return ERR_ADDR;
			case (ins.second_kind)
			KIND_REG: begin
				if (!reg_num_in_range(v2))
					return ERR_REG;
				reg_file[v2] = data_mem[v1];
			end
			KIND_CONST: data_mem[v1] = c2;
			default: return ERR_FORM;
			endcase
		end
		default: return ERR_FORM;
		endcase
		return ERR_NONE;
	endfunction

	function automatic err_t exec_arith(bit subtract, instr_t ins);
		longint            v1;
		logic [DATA_W-1:0] operand;
		err_t              e;
		v1 = longint'($signed(ins.first_value));
		if (ins.first_kind != KIND_REG)
			return ERR_FORM;
		if (!reg_num_in_range(v1))
			return ERR_REG;
		e = fetch_operand(ins.second_kind, longint'($signed(ins.second_value)), operand);
		if (e != ERR_NONE)
			return e;
		reg_file[v1] = subtract ? reg_file[v1] - operand : reg_file[v1] + operand;
		return ERR_NONE;
	endfunction

	// The target is range-checked even when the branch falls through.
	function automatic err_t cond_jump(bit on_nonpos, instr_t ins, output bit taken);
		longint            v1;
		logic [DATA_W-1:0] r;
		v1 = longint'($signed(ins.first_value));
		taken = 1'b0;
		if (ins.first_kind != KIND_REG)
			return ERR_FORM;
		if (!reg_num_in_range(v1))
			return ERR_REG;
		if (ins.second_kind != KIND_CONST)
			return ERR_FORM;
		if (!target_in_range(longint'($signed(ins.second_value))))
			return ERR_ADDR;
		r = reg_file[v1];
		taken = (r == '0) || (on_nonpos && r[DATA_W-1]);
		return ERR_NONE;
	endfunction

	function automatic result_t execute_step(instr_t ins);
		result_t            res;
		err_t               e;
		bit                 jump;
		bit                 printed;
		logic [PC_BITS-1:0] target;
		logic [DATA_W-1:0]  shown;
		e = ERR_NONE;
		jump = 1'b0;
		printed = 1'b0;
		target = '0;
		shown = '0;
		if (!machine_halted) begin
			case (ins.op)
			OP_MOV: e = exec_mov(ins);
			OP_ADD: e = exec_arith(1'b0, ins);
			OP_SUB: e = exec_arith(1'b1, ins);
			OP_JMP: begin
				if (ins.first_kind == KIND_CONST) begin
					if (!target_in_range(longint'($signed(ins.first_value)))) begin
						e = ERR_ADDR;
					end else begin
						jump = 1'b1;
						target = ins.first_value[PC_BITS-1:0];
					end
				end else begin
					e = cond_jump(1'b0, ins, jump);
					target = ins.second_value[PC_BITS-1:0];
				end
			end
			OP_JPN: begin
				e = cond_jump(1'b1, ins, jump);
				target = ins.second_value[PC_BITS-1:0];
			end
			OP_PRN: begin
				e = fetch_operand(ins.first_kind, longint'($signed(ins.first_value)), shown);
				printed = (e == ERR_NONE);
				if (!printed)
					shown = '0;
			end
			OP_HLT: machine_halted = 1'b1;
			default: e = ERR_OP;
			endcase
			// any slip halts and drops the jump
			if (e != ERR_NONE) begin
				machine_halted = 1'b1;
				jump = 1'b0;
			end
			line_pc = jump ? target : line_pc + 1'b1;
		end
		res.pc_after = PC_OUT_W'(line_pc);
		res.print_valid = printed;
		res.print_value = shown;
		res.halted = machine_halted;
		res.error_code = e;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			foreach (reg_file[i])
				reg_file[i] = '0;
			foreach (data_mem[i])
				data_mem[i] = '0;
			line_pc = PC_BITS'(1);
			machine_halted = 1'b0;
			expected_q.delete();
			fault_count = 0;
			mismatches <= 0;
			in_flight <= 0;
		end else begin
			if (instr.valid && instr.ready)
				expected_q.push_back(execute_step(instr.data));
			if (result.valid && result.ready) begin
				got = result.data;
				if (expected_q.size() == 0) begin
					if (fault_count < 10)
						$display({"%0t: result beat with nothing expected: ",
							"pc %0d prn %0b/%h halt %0b err %0d"},
							$realtime, got.pc_after, got.print_valid, got.print_value,
							got.halted, got.error_code);
					fault_count++;
				end else begin
					want = expected_q.pop_front();
					if (got.pc_after !== want.pc_after || got.print_valid !== want.print_valid ||
					    got.print_value !== want.print_value || got.halted !== want.halted ||
					    got.error_code !== want.error_code) begin
						if (fault_count < 10)
							$display({"%0t: mismatch: ",
								"expected pc %0d prn %0b/%h halt %0b err %0d, ",
								"got pc %0d prn %0b/%h halt %0b err %0d"},
								$realtime, want.pc_after, want.print_valid, want.print_value,
								want.halted, want.error_code, got.pc_after, got.print_valid,
								got.print_value, got.halted, got.error_code);
						fault_count++;
					end
				end
			end
			mismatches <= fault_count;
			in_flight <= expected_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the toy register machine step testbench: clock, reset, instruction stimulus,
// result back-pressure, watchdog and verdict. Depends on trms_pkg, the channel
// interfaces, the block itself and trms_result_check.
module testbench;
	import trms_pkg::*;

	localparam int RANDOM_ITEMS  = 1250;
	localparam int STALL_CYCLES  = 60;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 10;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   in_flight;
	bit   gaps_on = 1'b1;
	int   hold_req = 0;
	int   holds_served = 0;

	instr_if  instr ();
	result_if result ();

	toy_register_machine_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr.sink),
		.result (result.source)
	);

	trms_result_check u_result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr      (instr),
		.result     (result),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic instr_t make_instr(op_t op, kind_t k1, logic [DATA_W-1:0] v1,
	                                      kind_t k2, logic [DATA_W-1:0] v2);
		instr_t ins;
		ins.op = op;
		ins.first_kind = k1;
		ins.first_value = v1;
		ins.second_kind = k2;
		ins.second_value = v2;
		return ins;
	endfunction

	function automatic logic [DATA_W-1:0] pick_const();
		case ($urandom_range(0, 3))
		0: return $urandom();
		1: return $urandom_range(0, 8) - 4;
		2: case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h7fff_ffff;
			default: return 32'h8000_0000;
			endcase
		default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_target();
		case ($urandom_range(0, 7))
		0: return 0;
		1: return (1 << PC_BITS) - 1;
		default: return $urandom_range(0, (1 << PC_BITS) - 1);
		endcase
	endfunction

	function automatic void pick_source(output kind_t k, output logic [DATA_W-1:0] v);
		case ($urandom_range(0, 2))
		0: begin
			k = KIND_REG;
			v = $urandom_range(1, REG_COUNT);
		end
		1: begin
			k = KIND_MEM;
			v = $urandom_range(0, MEM_WORDS - 1);
		end
		default: begin
			k = KIND_CONST;
			v = pick_const();
		end
		endcase
	endfunction

	// Well-formed instruction with random content; ignored operands carry junk.
	function automatic instr_t random_good();
		logic [DATA_W-1:0] junk;
		kind_t             junk_kind;
		kind_t             k;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] r1;
		logic [DATA_W-1:0] r2;
		logic [DATA_W-1:0] a;
		junk = $urandom();
		junk_kind = kind_t'($urandom_range(0, 3));
		r1 = $urandom_range(1, REG_COUNT);
		r2 = $urandom_range(1, REG_COUNT);
		a = $urandom_range(0, MEM_WORDS - 1);
		case ($urandom_range(0, 10))
		0: return make_instr(OP_MOV, KIND_REG, r1, KIND_REG, r2);
		1: return make_instr(OP_MOV, KIND_REG, r1, KIND_MEM, a);
		2: return make_instr(OP_MOV, KIND_REG, r1, KIND_CONST, pick_const());
		3: return make_instr(OP_MOV, KIND_MEM, a, KIND_REG, r2);
		4: return make_instr(OP_MOV, KIND_MEM, a, KIND_CONST, pick_const());
		5, 6: begin
			pick_source(k, v);
			return make_instr($urandom_range(0, 1) ? OP_SUB : OP_ADD, KIND_REG, r1, k, v);
		end
		7: begin
			if ($urandom_range(0, 1))
				return make_instr(OP_JMP, KIND_CONST, pick_target(), junk_kind, junk);
			return make_instr(OP_JMP, KIND_REG, r1, KIND_CONST, pick_target());
		end
		8: return make_instr(OP_JPN, KIND_REG, r1, KIND_CONST, pick_target());
		default: begin
			pick_source(k, v);
			return make_instr(OP_PRN, k, v, junk_kind, junk);
		end
		endcase
	endfunction

	// One instruction that ends the machine's life: a halt or one of the slips.
	function automatic instr_t random_fatal();
		logic [DATA_W-1:0] neg;
		logic [DATA_W-1:0] r1;
		neg = $urandom() | 32'h8000_0000;
		r1 = $urandom_range(1, REG_COUNT);
		case ($urandom_range(0, 13))
		0: return make_instr(OP_HLT, kind_t'($urandom_range(0, 3)), $urandom(),
		                     kind_t'($urandom_range(0, 3)), $urandom());
		1: return make_instr(OP_BAD, KIND_REG, r1, KIND_REG, r1);
		2: return make_instr(OP_MOV, KIND_NONE, $urandom(), KIND_REG, r1);
		3: return make_instr(OP_MOV, KIND_REG, r1, KIND_NONE, $urandom());
		4: return make_instr(OP_ADD, KIND_MEM, 0, KIND_CONST, 1);
		5: return make_instr(OP_JMP, KIND_REG, r1, KIND_MEM, 3);
		6: return make_instr(OP_MOV, KIND_MEM, MEM_WORDS, KIND_CONST, $urandom());
		7: return make_instr(OP_PRN, KIND_MEM, neg, KIND_NONE, 0);
		8: return make_instr(OP_JMP, KIND_CONST, $urandom_range(0, 1) ? neg : 1 << PC_BITS,
		                     KIND_NONE, 0);
		9: return make_instr(OP_JPN, KIND_REG, r1, KIND_CONST, (1 << PC_BITS) + $urandom_range(0, 9));
		10: return make_instr(OP_MOV, KIND_REG, 0, KIND_CONST, 5);
		11: return make_instr(OP_SUB, KIND_REG, r1, KIND_REG, $urandom_range(0, 1) ? neg : REG_COUNT + 1);
		12: return make_instr(OP_MOV, KIND_MEM, 1, KIND_MEM, 2);
		default: return make_instr(OP_PRN, KIND_NONE, $urandom(), KIND_CONST, $urandom());
		endcase
	endfunction

	task automatic send_instr(input instr_t ins);
		if (gaps_on && $urandom_range(0, 99) < 5) begin
			instr.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		instr.valid <= 1'b1;
		instr.data <= ins;
		@(posedge clk);
		while (!instr.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		instr.valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	task automatic run_directed();
		send_instr(make_instr(OP_PRN, KIND_REG, REG_COUNT, KIND_NONE, 0));
		send_instr(make_instr(OP_PRN, KIND_MEM, MEM_WORDS - 1, KIND_NONE, 0));
		send_instr(make_instr(OP_MOV, KIND_REG, 1, KIND_CONST, 32'h7fff_ffff));
		send_instr(make_instr(OP_ADD, KIND_REG, 1, KIND_CONST, 1));
		send_instr(make_instr(OP_PRN, KIND_REG, 1, KIND_REG, 2));
		send_instr(make_instr(OP_MOV, KIND_REG, 2, KIND_CONST, 32'hffff_ffff));
		send_instr(make_instr(OP_ADD, KIND_REG, 2, KIND_CONST, 1));
		send_instr(make_instr(OP_JMP, KIND_REG, 2, KIND_CONST, 100));
		send_instr(make_instr(OP_MOV, KIND_REG, 1, KIND_MEM, MEM_WORDS - 1));
		send_instr(make_instr(OP_MOV, KIND_MEM, MEM_WORDS - 1, KIND_REG, 5));
		send_instr(make_instr(OP_MOV, KIND_MEM, 0, KIND_CONST, 32'h8000_0000));
		send_instr(make_instr(OP_SUB, KIND_REG, 5, KIND_MEM, 0));
		send_instr(make_instr(OP_MOV, KIND_REG, 1, KIND_REG, 3));
		send_instr(make_instr(OP_SUB, KIND_REG, 4, KIND_REG, 3));
		send_instr(make_instr(OP_PRN, KIND_CONST, 32'h8000_0000, KIND_NONE, 32'hffff_ffff));
		send_instr(make_instr(OP_PRN, KIND_CONST, 32'h7fff_ffff, KIND_MEM, 32'h8000_0000));
		// negative register takes the branch; the next step wraps the line counter
		send_instr(make_instr(OP_JPN, KIND_REG, 3, KIND_CONST, (1 << PC_BITS) - 1));
		send_instr(make_instr(OP_PRN, KIND_MEM, 0, KIND_CONST, 0));
		send_instr(make_instr(OP_JPN, KIND_REG, 2, KIND_CONST, 0));
		send_instr(make_instr(OP_MOV, KIND_REG, 4, KIND_CONST, 1));
		send_instr(make_instr(OP_JPN, KIND_REG, 4, KIND_CONST, 5));
		send_instr(make_instr(OP_JMP, KIND_REG, 4, KIND_CONST, (1 << PC_BITS) - 1));
		send_instr(make_instr(OP_JMP, KIND_CONST, 0, KIND_NONE, 32'hffff_ffff));
		send_instr(make_instr(OP_JMP, KIND_CONST, (1 << PC_BITS) - 1, KIND_REG, 0));
	endtask

	// Sender: directed, random programme, one fatal beat, then beats the halted machine ignores.
	initial begin
		instr.valid <= 1'b0;
		instr.data <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		run_directed();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			gaps_on <= !(i >= 450 && i < 650);
			if (i == 300)
				hold_req <= hold_req + 1;
			if (i == 800)
				wait_drained();
			send_instr(random_good());
		end
		send_instr(random_fatal());
		repeat (15)
			send_instr(make_instr(op_t'($urandom_range(0, 7)), kind_t'($urandom_range(0, 3)),
			                      $urandom(), kind_t'($urandom_range(0, 3)), $urandom()));
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("toy_register_machine_step regression: pass");
		else
			$display("toy_register_machine_step regression: fail");
		$finish;
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req != holds_served) begin
				holds_served++;
				result.ready <= 1'b0;
				repeat (STALL_CYCLES - 1) @(posedge clk);
			end else begin
				result.ready <= !gaps_on || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((instr.valid && instr.ready) || (result.valid && result.ready))
				idle = 0;
			else
				idle++;
		end
		$display("toy_register_machine_step regression: fail");
		$finish;
	end

endmodule
